### rtl/mmalu_pkg.sv
package mmalu_pkg;

  localparam int LIMB_W     = 32;
  localparam int NUM_LIMBS  = 5;
  localparam int WORD_W     = LIMB_W * NUM_LIMBS;
  localparam int VAL_W      = 131;
  localparam int PROD_W     = 2 * WORD_W;
  localparam int MUL_STAGES = 5;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [2:0] {
    FN_ADD = 3'd0,
    FN_SUB = 3'd1,
    FN_NEG = 3'd2,
    FN_MUL = 3'd3,
    FN_SQR = 3'd4
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MOD_LO = 3'd0,
    CFG_MOD_MID = 3'd1,
    CFG_MOD_HI = 3'd2,
    CFG_K_LO = 3'd3,
    CFG_K_MID = 3'd4,
    CFG_K_HI = 3'd5
  } cfg_idx_t;

endpackage

### rtl/mmalu_mul.sv
module mmalu_mul (
  input  logic                        clk,
  input  logic                        en,
  input  logic [mmalu_pkg::WORD_W-1:0] x,
  input  logic [mmalu_pkg::WORD_W-1:0] y,
  output logic [mmalu_pkg::PROD_W-1:0] prod
);
  import mmalu_pkg::*;

  logic [2*LIMB_W-1:0] pp [NUM_LIMBS][NUM_LIMBS];
  logic [6*LIMB_W-1:0] row [NUM_LIMBS];
  logic [7*LIMB_W-1:0] s01, s23;
  logic [9*LIMB_W-1:0] s0123;
  logic [6*LIMB_W-1:0] r4d, r4dd;

  // stage 1: limb partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_LIMBS; i++) begin
        for (int j = 0; j < NUM_LIMBS; j++) begin
          pp[i][j] <= x[i*LIMB_W +: LIMB_W] * y[j*LIMB_W +: LIMB_W];
        end
      end
    end
  end

  // stage 2: one row per limb of x, even and odd products interleave
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_LIMBS; i++) begin
        row[i] <= {pp[i][4], pp[i][2], pp[i][0]}
                + {{LIMB_W{1'b0}}, pp[i][3], pp[i][1], {LIMB_W{1'b0}}};
      end
    end
  end

  // stage 3: pairwise row sums
  always_ff @(posedge clk) begin
    if (en) begin
      s01 <= {{LIMB_W{1'b0}}, row[0]} + {row[1], {LIMB_W{1'b0}}};
      s23 <= {{LIMB_W{1'b0}}, row[2]} + {row[3], {LIMB_W{1'b0}}};
      r4d <= row[4];
    end
  end

  // stage 4
  always_ff @(posedge clk) begin
    if (en) begin
      s0123 <= {{(2*LIMB_W){1'b0}}, s01} + {s23, {(2*LIMB_W){1'b0}}};
      r4dd  <= r4d;
    end
  end

  // stage 5: full product
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= {{LIMB_W{1'b0}}, s0123} + {r4dd, {(4*LIMB_W){1'b0}}};
    end
  end

endmodule

### rtl/mmalu_lin.sv
module mmalu_lin (
  input  logic                        clk,
  input  logic                        en,
  input  mmalu_pkg::func_t            func,
  input  logic [mmalu_pkg::VAL_W-1:0] a,
  input  logic [mmalu_pkg::VAL_W-1:0] b,
  input  logic [mmalu_pkg::VAL_W-1:0] p,
  output logic [mmalu_pkg::VAL_W-1:0] res
);
  import mmalu_pkg::*;

  logic [VAL_W:0]   sum1, diff1;
  logic [VAL_W-1:0] neg1;
  logic             az1;
  func_t            f1;
  logic [VAL_W+1:0] sub_p;
  logic [VAL_W-1:0] add_r, sub_r, neg_r;

  // stage 1: raw sum, difference with borrow, p - a
  always_ff @(posedge clk) begin
    if (en) begin
      sum1  <= {1'b0, a} + {1'b0, b};
      diff1 <= {1'b0, a} - {1'b0, b};
      neg1  <= p - a;
      az1   <= (a == '0);
      f1    <= func;
    end
  end

  // stage 2: one correction by p
  always_comb begin
    sub_p = {1'b0, sum1} - {2'b0, p};
    add_r = sub_p[VAL_W+1] ? sum1[VAL_W-1:0] : sub_p[VAL_W-1:0];
    sub_r = diff1[VAL_W] ? diff1[VAL_W-1:0] + p : diff1[VAL_W-1:0];
    neg_r = az1 ? '0 : neg1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (f1)
        FN_ADD:  res <= add_r;
        FN_SUB:  res <= sub_r;
        FN_NEG:  res <= neg_r;
        default: res <= '0;
      endcase
    end
  end

endmodule

### rtl/montgomery_modular_alu_131.sv
// channel  | handshake                   | payload
// config   | cfg_we                      | cfg_index, cfg_data
// input    | in_valid / in_ready         | func, a_lo/mid/hi, b_lo/mid/hi
// output   | out_valid / out_ready       | result_lo/mid/hi
//
// three 160x160 multipliers of 5 stages each (product,
// k times low half, m times p), then the reduction add and the final compare.
// one item per cycle; the whole pipeline advances while the output register
// is empty or taken, and freezes in place otherwise.
// synchronous reset clears valid bits and configuration registers.
module montgomery_modular_alu_131 (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mmalu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mmalu_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      func,
  input  logic [63:0]                     a_lo,
  input  logic [63:0]                     a_mid,
  input  logic [2:0]                      a_hi,
  input  logic [63:0]                     b_lo,
  input  logic [63:0]                     b_mid,
  input  logic [2:0]                      b_hi,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [63:0]                     result_lo,
  output logic [63:0]                     result_mid,
  output logic [2:0]                      result_hi
);
  import mmalu_pkg::*;

  localparam int S_M1  = MUL_STAGES;
  localparam int S_M3  = 3 * MUL_STAGES;
  localparam int S_ADD = S_M3 + 1;
  localparam int S_OUT = S_M3 + 2;

  logic [63:0] mod_lo, mod_mid, k_lo, k_mid;
  logic [2:0]  mod_hi;
  logic [31:0] k_hi;
  logic [VAL_W-1:0]  p;
  logic [WORD_W-1:0] k, p_w;

  logic en;
  logic [S_OUT:1] vld;
  func_t func_pipe [1:S_ADD];
  logic [VAL_W-1:0]  lin_out;
  logic [VAL_W-1:0]  lin_pipe [3:S_ADD];
  logic [WORD_W-1:0] thi_pipe [S_M1+1:S_M3];
  logic [S_M3:S_M1+1] nz_pipe;
  logic [VAL_W-1:0]  a_v, b_v, y_v;
  logic [PROD_W-1:0] prod1, prod2, prod3;
  logic [WORD_W-1:0] r_sum;
  logic [WORD_W:0]   r_sub;
  logic [VAL_W-1:0]  mont_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mod_lo <= '0; mod_mid <= '0; mod_hi <= '0;
      k_lo <= '0; k_mid <= '0; k_hi <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MOD_LO:  mod_lo <= cfg_data;
        CFG_MOD_MID: mod_mid <= cfg_data;
        CFG_MOD_HI:  mod_hi <= cfg_data[2:0];
        CFG_K_LO:    k_lo <= cfg_data;
        CFG_K_MID:   k_mid <= cfg_data;
        CFG_K_HI:    k_hi <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign p   = {mod_hi, mod_mid, mod_lo};
  assign p_w = {{(WORD_W-VAL_W){1'b0}}, p};
  assign k   = {k_hi, k_mid, k_lo};
  assign a_v = {a_hi, a_mid, a_lo};
  assign b_v = {b_hi, b_mid, b_lo};
  assign y_v = (func_t'(func) == FN_SQR) ? a_v : b_v;

  // global advance
  assign en       = !vld[S_OUT] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[S_OUT-1:1], in_valid};
    end
  end

  // sideband delay lines
  always_ff @(posedge clk) begin
    if (en) begin
      func_pipe[1] <= func_t'(func);
      for (int i = 2; i <= S_ADD; i++) func_pipe[i] <= func_pipe[i-1];
      lin_pipe[3] <= lin_out;
      for (int i = 4; i <= S_ADD; i++) lin_pipe[i] <= lin_pipe[i-1];
      thi_pipe[S_M1+1] <= prod1[PROD_W-1:WORD_W];
      nz_pipe[S_M1+1]  <= |prod1[WORD_W-1:0];
      for (int i = S_M1 + 2; i <= S_M3; i++) begin
        thi_pipe[i] <= thi_pipe[i-1];
        nz_pipe[i]  <= nz_pipe[i-1];
      end
    end
  end

  // add, subtract, negate
  mmalu_lin u_lin (
    .clk(clk), .en(en), .func(func_t'(func)), .a(a_v), .b(b_v), .p(p), .res(lin_out)
  );

  // product, m = t_lo * k, m * p
  mmalu_mul u_mul_t (
    .clk(clk), .en(en), .x({{(WORD_W-VAL_W){1'b0}}, a_v}),
    .y({{(WORD_W-VAL_W){1'b0}}, y_v}), .prod(prod1)
  );
  mmalu_mul u_mul_m (
    .clk(clk), .en(en), .x(prod1[WORD_W-1:0]), .y(k), .prod(prod2)
  );
  mmalu_mul u_mul_u (
    .clk(clk), .en(en), .x(prod2[WORD_W-1:0]), .y(p_w), .prod(prod3)
  );

  // reduction sum
  always_ff @(posedge clk) begin
    if (en) begin
      r_sum <= thi_pipe[S_M3] + prod3[PROD_W-1:WORD_W]
             + {{(WORD_W-1){1'b0}}, nz_pipe[S_M3]};
    end
  end

  // final subtraction and result select
  assign r_sub  = {1'b0, r_sum} - {1'b0, p_w};
  assign mont_r = r_sub[WORD_W] ? r_sum[VAL_W-1:0] : r_sub[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      case (func_pipe[S_ADD])
        FN_ADD, FN_SUB, FN_NEG: {result_hi, result_mid, result_lo} <= lin_pipe[S_ADD];
        FN_MUL, FN_SQR:         {result_hi, result_mid, result_lo} <= mont_r;
        default:                {result_hi, result_mid, result_lo} <= '0;
      endcase
    end
  end

  assign out_valid = vld[S_OUT];

  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    en && vld[S_ADD] && func_pipe[S_ADD] != FN_ADD && func_pipe[S_ADD] != FN_SUB &&
    func_pipe[S_ADD] != FN_NEG && func_pipe[S_ADD] != FN_MUL &&
    func_pipe[S_ADD] != FN_SQR |=> result_lo == '0 && result_mid == '0 && result_hi == '0)
    else $error("unknown opcode gave nonzero result");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && vld == '0)
    else $error("pipeline not empty after reset");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mmalu_pkg::*;

  localparam int WDOG_LIMIT = 20000;
  localparam int DRAIN_CYC  = 40;
  localparam int N_RANDOM   = 1600;

  localparam logic [2:0] FN_BAD5 = 3'd5;
  localparam logic [2:0] FN_BAD7 = 3'd7;

  // a residue as the block sees it
  typedef logic [130:0] val_t;

  typedef struct packed {
    logic [2:0] fn;
    val_t       a;
    val_t       b;
    logic       known;
    val_t       res;
  } vec_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  func;
  logic [63:0] a_lo, a_mid, b_lo, b_mid;
  logic [2:0]  a_hi, b_hi;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] result_lo, result_mid;
  logic [2:0]  result_hi;

  montgomery_modular_alu_131 u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .func(func),
    .a_lo(a_lo), .a_mid(a_mid), .a_hi(a_hi),
    .b_lo(b_lo), .b_mid(b_mid), .b_hi(b_hi),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_lo(result_lo), .result_mid(result_mid), .result_hi(result_hi)
  );

  // shadow of the modulus and montgomery constant
  val_t         modulus;
  logic [159:0] neg_inv;

  val_t   residue_q[$];
  int     errors;
  int     idle_cycles;
  int     send_idle_pct;
  int     recv_stall_pct;
  bit     hold_recv;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // montgomery product a*b/R with one final subtraction
  function automatic val_t mont_product(val_t x, val_t y);
    logic [319:0] t;
    logic [319:0] mk;
    logic [319:0] mp;
    logic [159:0] r;
    logic [159:0] p160;
    t    = {189'd0, x} * {189'd0, y};
    mk   = {160'd0, t[159:0]} * {160'd0, neg_inv};
    mp   = {160'd0, mk[159:0]} * {189'd0, modulus};
    p160 = {29'd0, modulus};
    r    = t[319:160] + mp[319:160] + {159'd0, (t[159:0] != 0)};
    if (r >= p160) r = r - p160;
    return r[130:0];
  endfunction

  function automatic val_t modular_result(logic [2:0] fn, val_t a, val_t b);
    logic [159:0] s;
    val_t r;
    r = '0;
    case (fn)
      FN_ADD: begin
        s = {29'd0, a} + {29'd0, b};
        if (s >= {29'd0, modulus}) s = s - {29'd0, modulus};
        r = s[130:0];
      end
      FN_SUB: begin
        r = a - b;
        if (a < b) r = r + modulus;
      end
      FN_NEG: r = (a == 0) ? '0 : modulus - a;
      FN_MUL: r = mont_product(a, b);
      FN_SQR: r = mont_product(a, a);
      default: r = '0;
    endcase
    return r;
  endfunction

  // inverse of -p mod 2^160 by newton iteration
  function automatic logic [159:0] calc_neg_inv(val_t p);
    logic [159:0] x;
    logic [159:0] pp;
    pp = {29'd0, p};
    x = 160'd1;
    for (int i = 0; i < 8; i++) x = x * (160'd2 - pp * x);
    return -x;
  endfunction

  function automatic val_t rand_val();
    return {3'($urandom_range(7, 0)), $urandom, $urandom, $urandom, $urandom};
  endfunction

  // random operand, mostly below p, with edge and unreduced values now and then
  function automatic val_t rand_operand();
    val_t v;
    case ($urandom_range(9, 0))
      0: v = '0;
      1: v = (modulus == 0) ? '0 : modulus - 1;
      2: v = 131'd1;
      3: v = rand_val();
      default: begin
        v = rand_val();
        if (modulus != 0) v = v % modulus;
      end
    endcase
    return v;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [63:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_MOD_LO:  modulus[63:0]    = data;
      CFG_MOD_MID: modulus[127:64]  = data;
      CFG_MOD_HI:  modulus[130:128] = data[2:0];
      CFG_K_LO:    neg_inv[63:0]    = data;
      CFG_K_MID:   neg_inv[127:64]  = data;
      CFG_K_HI:    neg_inv[159:128] = data[31:0];
      default: ;
    endcase
  endtask

  task automatic load_modulus(val_t p, logic [159:0] k);
    write_reg(CFG_MOD_LO, p[63:0]);
    write_reg(CFG_MOD_MID, p[127:64]);
    write_reg(CFG_MOD_HI, {61'd0, p[130:128]});
    write_reg(CFG_K_LO, k[63:0]);
    write_reg(CFG_K_MID, k[127:64]);
    write_reg(CFG_K_HI, {32'd0, k[159:128]});
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (residue_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  // offer one item and hold it until accepted
  task automatic send_item(logic [2:0] fn, val_t a, val_t b, bit known, val_t res);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func     <= fn;
    a_lo <= a[63:0];  a_mid <= a[127:64];  a_hi <= a[130:128];
    b_lo <= b[63:0];  b_mid <= b[127:64];  b_hi <= b[130:128];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    residue_q.push_back(known ? res : modular_result(fn, a, b));
    @(negedge clk);
  endtask

  task automatic random_items(int n);
    logic [2:0] fn;
    for (int i = 0; i < n; i++) begin
      fn = ($urandom_range(49, 0) == 0) ? 3'($urandom_range(7, 5))
                                        : 3'($urandom_range(4, 0));
      send_item(fn, rand_operand(), rand_operand(), 1'b0, '0);
    end
  endtask

  // result checking at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (residue_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, {result_hi, result_mid, result_lo});
        errors++;
      end else begin
        val_t exp_r;
        exp_r = residue_q.pop_front();
        if (result_lo !== exp_r[63:0]) begin
          $display("%0t: result_lo expected %h actual %h", $time, exp_r[63:0], result_lo);
          errors++;
        end
        if (result_mid !== exp_r[127:64]) begin
          $display("%0t: result_mid expected %h actual %h", $time, exp_r[127:64],
                   result_mid);
          errors++;
        end
        if (result_hi !== exp_r[130:128]) begin
          $display("%0t: result_hi expected %h actual %h", $time, exp_r[130:128],
                   result_hi);
          errors++;
        end
      end
    end
  end

  // receiver stalls, with a long forced hold-off on request
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_recv) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || hold_recv)
      idle_cycles <= 0;
    else if (in_valid || residue_q.size() != 0)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("FAIL montgomery_modular_alu_131");
      $finish;
    end
  end

  vec_t dir_tab[$];
  val_t p_a, p_b, top;

  initial begin
    errors = 0; idle_cycles = 0; hold_recv = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0;
    modulus = '0; neg_inv = '0;
    rst = 1'b1; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; func = '0;
    a_lo = '0; a_mid = '0; a_hi = '0; b_lo = '0; b_mid = '0; b_hi = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // after reset p and k are zero; a nonzero low product still carries one
    send_item(FN_ADD, 131'd5, 131'd7, 1'b1, 131'd12);
    send_item(FN_MUL, 131'd3, 131'd4, 1'b1, 131'd1);
    wait_drained();

    // largest 131-bit prime-like odd modulus
    p_a = {3'd7, {128{1'b1}}} - 131'd14;
    load_modulus(p_a, calc_neg_inv(p_a));
    top = p_a - 1;
    dir_tab = '{
      '{FN_ADD, top, top, 1'b1, top - 1},
      '{FN_ADD, top, 131'd1, 1'b1, 131'd0},
      '{FN_ADD, 131'd0, 131'd0, 1'b1, 131'd0},
      '{FN_SUB, 131'd0, 131'd1, 1'b1, top},
      '{FN_SUB, top, top, 1'b1, 131'd0},
      '{FN_NEG, 131'd0, 131'd9, 1'b1, 131'd0},
      '{FN_NEG, 131'd1, 131'd0, 1'b1, top},
      '{FN_NEG, top, 131'd0, 1'b1, 131'd1},
      '{FN_MUL, 131'd0, top, 1'b1, 131'd0},
      '{FN_MUL, top, top, 1'b0, 131'd0},
      '{FN_MUL, 131'd1, 131'd1, 1'b0, 131'd0},
      '{FN_SQR, top, 131'd0, 1'b0, 131'd0},
      '{FN_SQR, 131'd0, top, 1'b1, 131'd0},
      '{FN_BAD5, top, top, 1'b1, 131'd0},
      '{FN_BAD7, top, top, 1'b1, 131'd0},
      '{FN_ADD, {131{1'b1}}, {131{1'b1}}, 1'b0, 131'd0},
      '{FN_SUB, 131'd3, {131{1'b1}}, 1'b0, 131'd0},
      '{FN_MUL, {131{1'b1}}, {131{1'b1}}, 1'b0, 131'd0},
      '{3'd6, 131'd1, 131'd2, 1'b1, 131'd0}
    };
    foreach (dir_tab[i])
      send_item(dir_tab[i].fn, dir_tab[i].a, dir_tab[i].b, dir_tab[i].known,
                dir_tab[i].res);
    wait_drained();

    // random phases under several moduli and idling mixes
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: p_b = 131'd3;
        1: p_b = rand_val() | 131'd1 | (131'd1 << 130);
        2: p_b = {64'd0, $urandom, $urandom} | 131'd1;
        3: p_b = p_a;
        default: p_b = rand_val() | 131'd1;
      endcase
      load_modulus(p_b, calc_neg_inv(p_b));
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        3: begin send_idle_pct = 38; recv_stall_pct = 38; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (ph == 4) begin
        // long receiver hold-off so the pipeline fills and stalls input
        fork
          begin
            hold_recv = 1'b1;
            repeat (200) @(negedge clk);
            hold_recv = 1'b0;
          end
          random_items(N_RANDOM / 5);
        join
      end else begin
        random_items(N_RANDOM / 5);
      end
      // sender pauses until every result has come
      wait_drained();
    end

    // wrong constant k and random modulus: same steps, operands not reduced below p
    load_modulus(rand_val(), {$urandom, $urandom, $urandom, $urandom, $urandom});
    send_idle_pct = 0; recv_stall_pct = 0;
    for (int i = 0; i < 40; i++)
      send_item(3'($urandom_range(4, 0)), rand_val(), rand_val(), 1'b0, '0);
    wait_drained();

    if (errors == 0) $display("PASS montgomery_modular_alu_131");
    else $display("FAIL montgomery_modular_alu_131");
    $finish;
  end

endmodule
